// File: rtl/mnci_pkg.sv
package mnci_pkg;

    localparam int CLAMP_FLOOR = -25600;
    localparam int FOCUS_BITS  = 16;
    localparam int DIV_STEPS   = 16;
    localparam int STEP_BITS   = 4;
    localparam int LEAD_BITS   = 7;
    localparam logic [LEAD_BITS-1:0] LEAD_RESET = 7'd64;
    localparam logic [FOCUS_BITS-1:0] FOCUS_SAT = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_ACC,
        ST_MUL,
        ST_SUB,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic acc;
        logic mul;
        logic sub;
        logic div_step;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic out_full;
    } sts_t;

endpackage

// File: rtl/minmax_normalized_channel_index_core.sv
// Min-max normalized channel index. Each item is one lead sample (signed Q15.8), clamped
// from below at -100.0; lead_count leads (clamped to 2..MAX_LEADS) form a case, and a
// new lead_count takes effect from the next item. One sample is taken per cycle
// during a case, but the last lead waits while the output register is full. After the
// last lead, the input stalls while the datapath runs a multiply step, a subtract step, a
// 16-step restoring divider (one quotient bit per cycle) and an output load. The result
// sits in an output register; the next case is accepted up to its
// last lead while that result waits. focus_index is (n*max - sum) / ((max - min)*(n - 1))
// as Q0.16, truncated, saturating at 65535; it is 0 when all leads sit at the floor,
// and 0 with the flat flag in tuser when max equals min above the floor.
module minmax_normalized_channel_index_core #(
    parameter int MAX_LEADS   = 64,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [mnci_pkg::LEAD_BITS-1:0]         cfg_data,   // lead_count
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,    // sample
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [((SAMPLE_BITS+23)/8)*8-1:0]      m_tdata,    // focus_index, max_value
    output logic                                   m_tuser     // flat_case
);
    import mnci_pkg::*;

    localparam int MDW = ((SAMPLE_BITS + 23) / 8) * 8;

    cmd_t                   cmd;
    sts_t                   sts;
    logic [FOCUS_BITS-1:0]  focus_index;
    logic [SAMPLE_BITS-1:0] max_value;

    assign cfg_ready = 1'b1;

    mnci_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mnci_dp #(
        .MAX_LEADS   (MAX_LEADS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .sample      (s_tdata[SAMPLE_BITS-1:0]),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .focus_index (focus_index),
        .max_value   (max_value),
        .flat_case   (m_tuser),
        .cmd         (cmd),
        .sts         (sts)
    );

    assign m_tdata = MDW'({max_value, focus_index});

endmodule

// File: rtl/mnci_ctrl.sv
module mnci_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  mnci_pkg::sts_t sts,
    output mnci_pkg::cmd_t cmd
);
    import mnci_pkg::*;

    state_t                state_reg, state_next;
    logic [STEP_BITS-1:0]  step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACC;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_ACC: begin
                if (s_tvalid && !(sts.last && sts.out_full) && sts.last) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: state_next = ST_SUB;
            ST_SUB: begin
                state_next = ST_DIV;
                step_next  = '0;
            end
            ST_DIV: begin
                step_next = step_reg + STEP_BITS'(1);
                if (step_reg == STEP_BITS'(DIV_STEPS - 1)) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: state_next = ST_ACC;
            default: state_next = ST_ACC;
        endcase
    end

    always_comb begin
        s_tready     = 1'b0;
        cmd          = '0;
        case (state_reg)
            ST_ACC: begin
                s_tready = !(sts.last && sts.out_full);
                cmd.acc  = s_tvalid && !(sts.last && sts.out_full);
            end
            ST_MUL: cmd.mul = 1'b1;
            ST_SUB: cmd.sub = 1'b1;
            ST_DIV: cmd.div_step = 1'b1;
            ST_OUT: cmd.load = 1'b1;
            default: cmd = '0;
        endcase
    end

endmodule

// File: rtl/mnci_dp.sv
module mnci_dp #(
    parameter int MAX_LEADS   = 64,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    input  logic [mnci_pkg::LEAD_BITS-1:0]    cfg_data,
    input  logic [SAMPLE_BITS-1:0]            sample,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [mnci_pkg::FOCUS_BITS-1:0]   focus_index,
    output logic [SAMPLE_BITS-1:0]            max_value,
    output logic                              flat_case,
    input  mnci_pkg::cmd_t                    cmd,
    output mnci_pkg::sts_t                    sts
);
    import mnci_pkg::*;

    localparam int XW  = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
    localparam int LCW = $clog2(MAX_LEADS + 1);
    localparam int NW  = (LCW > LEAD_BITS) ? LCW : LEAD_BITS;
    localparam int SW  = XW + LCW;
    localparam int PW  = XW + LCW + 1;
    localparam int DW  = XW + LCW + 1;
    localparam logic signed [XW-1:0] FLOOR_X = XW'(CLAMP_FLOOR);

    logic [LEAD_BITS-1:0]   lead_count_reg;

    logic signed [XW-1:0]   max_reg, min_reg;
    logic signed [SW-1:0]   sum_reg;
    logic [LCW-1:0]         cnt_reg;

    logic signed [XW-1:0]   cmax_reg, cmin_reg;
    logic signed [SW-1:0]   csum_reg;
    logic [LCW-1:0]         cn_reg;

    logic signed [PW-1:0]   prod_reg;
    logic [DW-1:0]          den_reg;
    logic                   floor_reg, flat_reg, sat_reg;
    logic [DW-1:0]          rem_reg;
    logic [FOCUS_BITS-1:0]  quo_reg;

    logic                   out_valid_reg;
    logic [FOCUS_BITS-1:0]  out_focus_reg;
    logic [SAMPLE_BITS-1:0] out_max_reg;
    logic                   out_flat_reg;

    logic signed [SAMPLE_BITS-1:0] x_raw;
    logic signed [XW-1:0]   x_cl;
    logic signed [XW-1:0]   max_new, min_new;
    logic signed [SW-1:0]   sum_new;
    logic [LCW-1:0]         cnt_new;
    logic [NW-1:0]          lc_ext, n_eff;
    logic                   last;
    logic [XW:0]            diff;
    logic signed [PW-1:0]   mul_a, mul_b;
    logic [DW-1:0]          num;
    logic [DW:0]            rem2;

    assign x_raw   = sample;
    assign x_cl    = (XW'(x_raw) < FLOOR_X) ? FLOOR_X : XW'(x_raw);
    assign min_new = (cnt_reg == '0 || x_cl < min_reg) ? x_cl : min_reg;
    assign max_new = (x_cl > max_reg) ? x_cl : max_reg;
    assign sum_new = sum_reg + SW'(x_cl);
    assign cnt_new = cnt_reg + LCW'(1);

    always_comb begin
        lc_ext = NW'(lead_count_reg);
        if (lc_ext < NW'(2)) begin
            n_eff = NW'(2);
        end else if (lc_ext > NW'(MAX_LEADS)) begin
            n_eff = NW'(MAX_LEADS);
        end else begin
            n_eff = lc_ext;
        end
    end

    assign last = (NW'(cnt_new) >= n_eff);

    assign diff  = (XW+1)'(cmax_reg) - (XW+1)'(cmin_reg);
    assign mul_a = PW'(cmax_reg);
    assign mul_b = $signed(PW'(cn_reg));
    assign num   = DW'(prod_reg - PW'(csum_reg));
    assign rem2  = {rem_reg, 1'b0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lead_count_reg <= LEAD_RESET;
        end else if (cfg_valid) begin
            lead_count_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg <= FLOOR_X;
            min_reg <= '0;
            sum_reg <= '0;
            cnt_reg <= '0;
        end else if (cmd.acc) begin
            if (last) begin
                max_reg <= FLOOR_X;
                min_reg <= '0;
                sum_reg <= '0;
                cnt_reg <= '0;
            end else begin
                max_reg <= max_new;
                min_reg <= min_new;
                sum_reg <= sum_new;
                cnt_reg <= cnt_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.acc && last) begin
            cmax_reg <= max_new;
            cmin_reg <= min_new;
            csum_reg <= sum_new;
            cn_reg   <= cnt_new;
        end
        if (cmd.mul) begin
            prod_reg  <= mul_a * mul_b;
            den_reg   <= DW'(diff) * DW'(cn_reg - LCW'(1));
            floor_reg <= (cmax_reg == FLOOR_X);
            flat_reg  <= (cmax_reg == cmin_reg);
        end
        if (cmd.sub) begin
            rem_reg <= num;
            sat_reg <= (num >= den_reg);
            quo_reg <= '0;
        end
        if (cmd.div_step) begin
            if (rem2 >= {1'b0, den_reg}) begin
                rem_reg <= DW'(rem2 - {1'b0, den_reg});
                quo_reg <= {quo_reg[FOCUS_BITS-2:0], 1'b1};
            end else begin
                rem_reg <= DW'(rem2);
                quo_reg <= {quo_reg[FOCUS_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            out_max_reg  <= cmax_reg[SAMPLE_BITS-1:0];
            out_flat_reg <= !floor_reg && flat_reg;
            if (floor_reg || flat_reg) begin
                out_focus_reg <= '0;
            end else if (sat_reg) begin
                out_focus_reg <= FOCUS_SAT;
            end else begin
                out_focus_reg <= quo_reg;
            end
        end
    end

    assign sts.last     = last;
    assign sts.out_full = out_valid_reg;
    assign m_tvalid     = out_valid_reg;
    assign focus_index  = out_focus_reg;
    assign max_value    = out_max_reg;
    assign flat_case    = out_flat_reg;

endmodule
